>>> rtl/bcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_pkg
// Types and constants shared by the button gesture detector modules.
// ----------------------------------------------------------------------------
package bcg_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS = 2'd2;

	localparam logic [15:0] HOLD_TICKS_RST = 16'd100;
	localparam logic [15:0] SHORT_LIMIT_RST = 16'd50;
	localparam logic [7:0] GAP_TICKS_RST = 8'd25;

	localparam logic [15:0] HELD_MAX = 16'hFFFF;
	localparam logic [7:0] CNT_MAX = 8'hFF;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_TAKE_SINGLE = 2'd1,
		ACT_TAKE_DOUBLE = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef struct packed {
		logic [15:0] hold_ticks;
		logic [15:0] short_limit;
		logic [7:0] gap_ticks;
	} cfg_t;

	typedef struct packed {
		action_t action;
		logic button_pressed;
	} tick_t;

	typedef struct packed {
		logic count_ready;
		logic [7:0] clicks_seen;
		logic released;
		logic hold_active;
		logic double_press;
		logic single_press;
	} result_t;

endpackage

>>> rtl/bcg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_cfg
// Configuration register file: hold threshold, short-press limit and gap window.
// ----------------------------------------------------------------------------
module bcg_cfg (
	input logic clk,
	input logic arst_n,
	input logic we,
	input logic [bcg_pkg::CFG_IDX_W-1:0] index,
	input logic [bcg_pkg::CFG_DATA_W-1:0] data,
	output bcg_pkg::cfg_t cfg
);

	bcg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks <= bcg_pkg::HOLD_TICKS_RST;
			cfg_q.short_limit <= bcg_pkg::SHORT_LIMIT_RST;
			cfg_q.gap_ticks <= bcg_pkg::GAP_TICKS_RST;
		end else if (we) begin
			case (index)
				bcg_pkg::CFG_HOLD_TICKS: cfg_q.hold_ticks <= data;
				bcg_pkg::CFG_SHORT_LIMIT: cfg_q.short_limit <= data;
				bcg_pkg::CFG_GAP_TICKS: cfg_q.gap_ticks <= data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/bcg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_core
// Gesture state registers and the per-tick update, tick first, action second.
// ----------------------------------------------------------------------------
module bcg_core (
	input logic clk,
	input logic arst_n,
	input logic take,
	input bcg_pkg::tick_t tick,
	input bcg_pkg::cfg_t cfg,
	output bcg_pkg::result_t res
);

	logic last_level_q;
	logic [15:0] held_q;
	logic [7:0] click_q;
	logic [7:0] gap_q;
	logic ready_q;

	logic rel, is_click, take_any;
	logic [15:0] held_inc, held_nxt;
	logic [7:0] click_inc, click_nxt;
	logic [7:0] gap_a, gap_b, gap_nxt;
	logic rdy_a, rdy_nxt;

	always_comb begin
		rel = !tick.button_pressed && last_level_q;
		held_inc = (tick.button_pressed && last_level_q && held_q != bcg_pkg::HELD_MAX) ?
			held_q + 16'd1 : held_q;

		// click: short press released inside the gap window
		is_click = rel && (held_inc < cfg.short_limit) && (gap_q < cfg.gap_ticks);
		click_inc = (is_click && click_q != bcg_pkg::CNT_MAX) ? click_q + 8'd1 : click_q;
		gap_a = is_click ? 8'd0 : gap_q;
		rdy_a = is_click ? 1'b0 : ready_q;
		held_nxt = rel ? 16'd0 : held_inc;

		// window expired
		if (gap_a >= cfg.gap_ticks) begin
			rdy_nxt = 1'b1;
			gap_b = 8'd0;
		end else begin
			rdy_nxt = rdy_a;
			gap_b = gap_a;
		end
		gap_nxt = (!rdy_nxt && gap_b != bcg_pkg::CNT_MAX) ? gap_b + 8'd1 : gap_b;

		res.single_press = 1'b0;
		res.double_press = 1'b0;
		take_any = 1'b0;
		case (tick.action)
			bcg_pkg::ACT_TAKE_SINGLE: begin
				res.single_press = rdy_nxt && click_inc == 8'd1;
				take_any = res.single_press;
			end
			bcg_pkg::ACT_TAKE_DOUBLE: begin
				res.double_press = rdy_nxt && click_inc == 8'd2;
				take_any = res.double_press;
			end
			bcg_pkg::ACT_CLEAR: take_any = rdy_nxt;
			default: take_any = 1'b0;
		endcase
		click_nxt = take_any ? 8'd0 : click_inc;

		res.hold_active = held_nxt >= cfg.hold_ticks;
		res.released = rel;
		res.clicks_seen = click_nxt;
		res.count_ready = rdy_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			held_q <= 16'd0;
			click_q <= 8'd0;
			gap_q <= 8'd0;
			ready_q <= 1'b1;
		end else if (take) begin
			last_level_q <= tick.button_pressed;
			held_q <= held_nxt;
			click_q <= click_nxt;
			gap_q <= gap_nxt;
			ready_q <= rdy_nxt;
		end
	end

endmodule

>>> rtl/bcg_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcg_out
// Result register with valid flag; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module bcg_out (
	input logic clk,
	input logic arst_n,
	input logic load,
	input bcg_pkg::result_t res,
	input logic drain,
	output logic valid,
	output bcg_pkg::result_t res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (drain) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign valid = valid_q;

endmodule

>>> rtl/button_click_gesture_detector.sv
`timescale 1ns / 1ps
// An accepted request's result is registered and appears on m_tdata in the next cycle.
// Throughput: one request per cycle; the input side stalls only while the
// result register is full and m_tready is low.
// Reset (arst_n low): released level, counters and gap timer zero, count
// ready, result register empty, registers back to 100 / 50 / 25.
// ----------------------------------------------------------------------------
// button_click_gesture_detector
// Click, double click, hold and release detection on a stream of sampled
// button ticks, with clear-on-read of the click count.
// ----------------------------------------------------------------------------
module button_click_gesture_detector (
	input logic clk,
	input logic arst_n,
	// configuration write port
	input logic cfg_we,
	input logic [bcg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bcg_pkg::CFG_DATA_W-1:0] cfg_data,
	// request stream
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [0] button_pressed, [2:1] action, [7:3] zero
	// result stream
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata // [0] single_press, [1] double_press,
	// [2] hold_active, [3] released, [11:4] clicks_seen, [12] count_ready,
	// [15:13] zero
);

	bcg_pkg::cfg_t cfg;
	bcg_pkg::tick_t tick;
	bcg_pkg::result_t res, res_q;
	logic take;

	// A request is taken whenever the result register is empty or being
	// drained in the same cycle, so ticks flow back to back.
	assign s_tready = !m_tvalid || m_tready;
	assign take = s_tvalid && s_tready;

	assign tick.button_pressed = s_tdata[0];
	assign tick.action = bcg_pkg::action_t'(s_tdata[2:1]);

	bcg_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.we(cfg_we),
		.index(cfg_index),
		.data(cfg_data),
		.cfg(cfg)
	);

	// state update happens on the accepting edge; the result is captured
	// alongside it
	bcg_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.tick(tick),
		.cfg(cfg),
		.res(res)
	);

	bcg_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(take),
		.res(res),
		.drain(m_tready),
		.valid(m_tvalid),
		.res_q(res_q)
	);

	assign m_tdata = {3'b000, res_q.count_ready, res_q.clicks_seen, res_q.released,
		res_q.hold_active, res_q.double_press, res_q.single_press};

`ifndef SYNTH
	// a take only happens from a ready count and always clears it
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_q.single_press || res_q.double_press) |->
			res_q.count_ready && res_q.clicks_seen == 8'd0)
		else $error("press taken without ready count or count not cleared");

	a_one_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_q.single_press && res_q.double_press))
		else $error("single and double press in the same result");

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request produced no result");
`endif

endmodule
